FILE: rtl/mle_pkg.sv
package mle_pkg;

  localparam int CHAR_W  = 8;
  localparam int PITCH_W = 2;
  localparam int DUR_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SYM_CNT_W = 3;
  localparam int SYM_PAT_W = 4;

  // pitch codes
  localparam logic [PITCH_W-1:0] PITCH_SILENT = 2'd0;
  localparam logic [PITCH_W-1:0] PITCH_HIGH   = 2'd1;
  localparam logic [PITCH_W-1:0] PITCH_LOW    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOT_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_TIME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_GAP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 2'd3;

  // register reset values
  localparam logic [DUR_W-1:0] DOT_TIME_RST   = 16'd100;
  localparam logic [DUR_W-1:0] DASH_TIME_RST  = 16'd400;
  localparam logic [DUR_W-1:0] SYMBOL_GAP_RST = 16'd100;
  localparam logic [DUR_W-1:0] LETTER_GAP_RST = 16'd600;

  // ASCII bounds
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic                 is_letter;
    logic [SYM_CNT_W-1:0] count;    // symbols in the letter, 1..4
    logic [SYM_PAT_W-1:0] pattern;  // first symbol at msb, 1 = dash
  } morse_code_t;

  // Morse table; the function left aligns each pattern
  function automatic morse_code_t morse_lookup(input logic [CHAR_W-1:0] c);
    logic [4:0]           idx;
    logic [SYM_CNT_W-1:0] n;
    logic [SYM_PAT_W-1:0] b;
    morse_code_t          r;
    idx = 5'd0;
    n   = 3'd1;
    b   = 4'h0;
    r.is_letter = 1'b0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r.is_letter = 1'b1;
      idx = 5'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r.is_letter = 1'b1;
      idx = 5'(c - CHAR_LOWER_A);
    end
    case (idx)
      5'd0:  begin n = 3'd2; b = 4'h1; end
      5'd1:  begin n = 3'd4; b = 4'h8; end
      5'd2:  begin n = 3'd4; b = 4'hA; end
      5'd3:  begin n = 3'd3; b = 4'h4; end
      5'd4:  begin n = 3'd1; b = 4'h0; end
      5'd5:  begin n = 3'd4; b = 4'h2; end
      5'd6:  begin n = 3'd3; b = 4'h6; end
      5'd7:  begin n = 3'd4; b = 4'h0; end
      5'd8:  begin n = 3'd2; b = 4'h0; end
      5'd9:  begin n = 3'd4; b = 4'h7; end
      5'd10: begin n = 3'd3; b = 4'h5; end
      5'd11: begin n = 3'd4; b = 4'h4; end
      5'd12: begin n = 3'd2; b = 4'h3; end
      5'd13: begin n = 3'd2; b = 4'h2; end
      5'd14: begin n = 3'd3; b = 4'h7; end
      5'd15: begin n = 3'd4; b = 4'h6; end
      5'd16: begin n = 3'd4; b = 4'hD; end
      5'd17: begin n = 3'd3; b = 4'h2; end
      5'd18: begin n = 3'd3; b = 4'h0; end
      5'd19: begin n = 3'd1; b = 4'h1; end
      5'd20: begin n = 3'd3; b = 4'h1; end
      5'd21: begin n = 3'd4; b = 4'h1; end
      5'd22: begin n = 3'd3; b = 4'h3; end
      5'd23: begin n = 3'd4; b = 4'h9; end
      5'd24: begin n = 3'd4; b = 4'hB; end
      5'd25: begin n = 3'd4; b = 4'hC; end
      default: begin n = 3'd1; b = 4'h0; end
    endcase
    r.count   = n;
    r.pattern = SYM_PAT_W'(b << (3'd4 - n));
    return r;
  endfunction

endpackage

FILE: rtl/mle_if.sv
// character channel
interface mle_char_if import mle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// segment channel
interface mle_seg_if import mle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               light_on;
  logic [PITCH_W-1:0] pitch;
  logic [DUR_W-1:0]   duration_ms;
  logic               last;

  modport source (output valid, output light_on, output pitch, output duration_ms,
                  output last, input ready);
  modport sink   (input valid, input light_on, input pitch, input duration_ms,
                  input last, output ready);
endinterface

FILE: rtl/morse_letter_encoder_core.sv
// A letter is taken at the fetch step; the step counter then goes to the keyed step, from
// which its first segment is registered. A letter of n symbols gives 2*n+1 segments, one
// segment per cycle from the microcode step counter while the output does not stall; a
// non-letter gives no segment. Output stalls hold the step counter in place.
// Reset (synchronous, active high): step counter to fetch, output empty, timing registers
// to their default values.
module morse_letter_encoder_core import mle_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_wdata,
  mle_char_if.sink             char_in,
  mle_seg_if.source            seg_out
);

  typedef logic [1:0] step_t;

  localparam step_t STEP_FETCH = 2'd0;
  localparam step_t STEP_KEY   = 2'd1;
  localparam step_t STEP_GAP   = 2'd2;
  localparam step_t STEP_CLOSE = 2'd3;

  typedef enum logic [1:0] {SEG_NONE, SEG_KEY, SEG_GAP, SEG_CLOSE} seg_t;
  typedef enum logic [1:0] {COND_ALWAYS, COND_LETTER, COND_MORE_SYM} cond_t;

  typedef struct packed {
    logic  take_in;
    seg_t  seg;
    cond_t cond;
    step_t jump;   // taken when cond holds
    step_t fall;   // taken otherwise
  } ctl_word_t;

  // microcode program
  function automatic ctl_word_t ucode(input step_t s);
    ctl_word_t w;
    case (s)
      STEP_FETCH: w = '{1'b1, SEG_NONE,  COND_LETTER,   STEP_KEY,   STEP_FETCH};
      STEP_KEY:   w = '{1'b0, SEG_KEY,   COND_ALWAYS,   STEP_GAP,   STEP_GAP};
      STEP_GAP:   w = '{1'b0, SEG_GAP,   COND_MORE_SYM, STEP_KEY,   STEP_CLOSE};
      STEP_CLOSE: w = '{1'b0, SEG_CLOSE, COND_ALWAYS,   STEP_FETCH, STEP_FETCH};
      default:    w = '{1'b0, SEG_NONE,  COND_ALWAYS,   STEP_FETCH, STEP_FETCH};
    endcase
    return w;
  endfunction

  // timing registers
  logic [DUR_W-1:0] dot_time;
  logic [DUR_W-1:0] dash_time;
  logic [DUR_W-1:0] symbol_gap;
  logic [DUR_W-1:0] letter_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_time   <= DOT_TIME_RST;
      dash_time  <= DASH_TIME_RST;
      symbol_gap <= SYMBOL_GAP_RST;
      letter_gap <= LETTER_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOT_TIME:   dot_time   <= cfg_wdata;
        REG_DASH_TIME:  dash_time  <= cfg_wdata;
        REG_SYMBOL_GAP: symbol_gap <= cfg_wdata;
        REG_LETTER_GAP: letter_gap <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer state
  step_t                step;
  logic [SYM_CNT_W-1:0] remain;
  logic [SYM_PAT_W-1:0] pattern;
  logic                 out_valid;

  ctl_word_t   ctl;
  morse_code_t code;
  logic        slot_free;
  logic        go;
  logic        cond_true;
  logic        emit;
  logic [DUR_W:0] close_diff;
  logic [DUR_W-1:0] close_dur;

  assign ctl       = ucode(step);
  assign code      = morse_lookup(char_in.char_code);
  assign slot_free = !out_valid || seg_out.ready;
  assign emit      = (ctl.seg != SEG_NONE) && slot_free;
  assign go        = ctl.take_in ? char_in.valid : slot_free;

  // closing gap, saturated at zero
  assign close_diff = {1'b0, letter_gap} - {1'b0, symbol_gap};
  assign close_dur  = close_diff[DUR_W] ? '0 : close_diff[DUR_W-1:0];

  always_comb begin
    case (ctl.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_LETTER:   cond_true = code.is_letter;
      COND_MORE_SYM: cond_true = (remain != SYM_CNT_W'(1));
      default:       cond_true = 1'b0;
    endcase
  end

  assign char_in.ready = ctl.take_in;

  // step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_FETCH;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        step <= cond_true ? ctl.jump : ctl.fall;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (seg_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // symbol shifter and remaining count
  always_ff @(posedge clk) begin
    if (ctl.take_in && char_in.valid) begin
      remain  <= code.count;
      pattern <= code.pattern;
    end else if (ctl.seg == SEG_GAP && slot_free) begin
      remain  <= remain - SYM_CNT_W'(1);
      pattern <= {pattern[SYM_PAT_W-2:0], 1'b0};
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      case (ctl.seg)
        SEG_KEY: begin
          seg_out.light_on    <= 1'b1;
          seg_out.pitch       <= pattern[SYM_PAT_W-1] ? PITCH_LOW : PITCH_HIGH;
          seg_out.duration_ms <= pattern[SYM_PAT_W-1] ? dash_time : dot_time;
          seg_out.last        <= 1'b0;
        end
        SEG_GAP: begin
          seg_out.light_on    <= 1'b0;
          seg_out.pitch       <= PITCH_SILENT;
          seg_out.duration_ms <= symbol_gap;
          seg_out.last        <= 1'b0;
        end
        default: begin
          seg_out.light_on    <= 1'b0;
          seg_out.pitch       <= PITCH_SILENT;
          seg_out.duration_ms <= close_dur;
          seg_out.last        <= 1'b1;
        end
      endcase
    end
  end

  assign seg_out.valid = out_valid;

  // checks
  a_letter_starts_key: assert property (@(posedge clk) disable iff (rst)
    (char_in.valid && char_in.ready && code.is_letter) |=> (step == STEP_KEY))
    else $error("letter accepted but sequencer did not go to keyed step");

  a_nonletter_stays: assert property (@(posedge clk) disable iff (rst)
    (char_in.valid && char_in.ready && !code.is_letter) |=> (step == STEP_FETCH))
    else $error("non-letter left the fetch step");

  a_keyed_fields: assert property (@(posedge clk) disable iff (rst)
    (seg_out.valid && seg_out.light_on) |-> (seg_out.pitch != PITCH_SILENT && !seg_out.last))
    else $error("keyed segment with silent pitch or last flag");

  a_close_silent: assert property (@(posedge clk) disable iff (rst)
    (seg_out.valid && seg_out.last) |-> (!seg_out.light_on && seg_out.pitch == PITCH_SILENT))
    else $error("closing segment is not silent");

endmodule

FILE: sim/tb_morse_letter_encoder_core.sv
module tb_morse_letter_encoder_core;
  import mle_pkg::*;

  localparam int SETTLE_CYCLES = 14;
  localparam int HOLD_CYCLES   = 250;   // long receiver hold-off
  localparam int STALL_LIMIT   = 4000;  // cycles with no transaction at all
  localparam int PHASE_LETTERS = 34;
  localparam int MAX_PRINTS    = 100;

  typedef struct packed {
    logic               light_on;
    logic [PITCH_W-1:0] pitch;
    logic [DUR_W-1:0]   duration_ms;
    logic               last;
  } segment_t;

  // Predicts the segment stream of every accepted character and checks the DUT output
  class seg_scoreboard;
    logic [DUR_W-1:0] dot_ms;
    logic [DUR_W-1:0] dash_ms;
    logic [DUR_W-1:0] sym_gap_ms;
    logic [DUR_W-1:0] ltr_gap_ms;
    segment_t         expected_segs[$];
    int               errors;

    function new();
      dot_ms     = DOT_TIME_RST;
      dash_ms    = DASH_TIME_RST;
      sym_gap_ms = SYMBOL_GAP_RST;
      ltr_gap_ms = LETTER_GAP_RST;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] val);
      case (idx)
        REG_DOT_TIME:   dot_ms     = val;
        REG_DASH_TIME:  dash_ms    = val;
        REG_SYMBOL_GAP: sym_gap_ms = val;
        REG_LETTER_GAP: ltr_gap_ms = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_segs.size();
    endfunction

    // dots and dashes of a letter, empty for anything else
    function string morse_of(logic [CHAR_W-1:0] c);
      int idx;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) idx = int'(c - CHAR_UPPER_A);
      else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) idx = int'(c - CHAR_LOWER_A);
      else return "";
      case (idx)
        0:  return ".-";
        1:  return "-...";
        2:  return "-.-.";
        3:  return "-..";
        4:  return ".";
        5:  return "..-.";
        6:  return "--.";
        7:  return "....";
        8:  return "..";
        9:  return ".---";
        10: return "-.-";
        11: return ".-..";
        12: return "--";
        13: return "-.";
        14: return "---";
        15: return ".--.";
        16: return "--.-";
        17: return ".-.";
        18: return "...";
        19: return "-";
        20: return "..-";
        21: return "...-";
        22: return ".--";
        23: return "-..-";
        24: return "-.--";
        default: return "--..";
      endcase
    endfunction

    function void push_seg(logic light, logic [PITCH_W-1:0] p, logic [DUR_W-1:0] dur,
                           logic lst);
      segment_t s;
      s.light_on    = light;
      s.pitch       = p;
      s.duration_ms = dur;
      s.last        = lst;
      expected_segs.push_back(s);
    endfunction

    function void note_char(logic [CHAR_W-1:0] c);
      string code;
      code = morse_of(c);
      if (code.len() == 0) return;
      for (int i = 0; i < code.len(); i++) begin
        if (code[i] == "-") push_seg(1'b1, PITCH_LOW, dash_ms, 1'b0);
        else push_seg(1'b1, PITCH_HIGH, dot_ms, 1'b0);
        push_seg(1'b0, PITCH_SILENT, sym_gap_ms, 1'b0);
      end
      // closing silence saturates at zero
      push_seg(1'b0, PITCH_SILENT,
               (ltr_gap_ms > sym_gap_ms) ? DUR_W'(ltr_gap_ms - sym_gap_ms) : '0, 1'b1);
    endfunction

    task report_mismatch(string what);
      if (errors < MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_segment(segment_t got);
      segment_t want;
      if (expected_segs.size() == 0) begin
        report_mismatch($sformatf("unexpected segment %p", got));
        return;
      end
      want = expected_segs.pop_front();
      if (got.light_on !== want.light_on)
        report_mismatch($sformatf("light_on %0b, expected %0b", got.light_on, want.light_on));
      if (got.pitch !== want.pitch)
        report_mismatch($sformatf("pitch %0d, expected %0d", got.pitch, want.pitch));
      if (got.duration_ms !== want.duration_ms)
        report_mismatch($sformatf("duration_ms %0d, expected %0d",
                                  got.duration_ms, want.duration_ms));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0]     cfg_wdata;

  mle_char_if char_if();
  mle_seg_if  seg_if();

  seg_scoreboard sb = new();

  int src_idle;
  int sink_idle;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int stall_cycles;

  morse_letter_encoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .char_in   (char_if),
    .seg_out   (seg_if)
  );

  // 4-unit clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      seg_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      seg_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      seg_if.ready <= 1'b0;
    end else begin
      seg_if.ready <= ($urandom_range(0, 99) >= sink_idle);
    end
  end

  // segment monitor
  always @(posedge clk) begin
    segment_t got;
    if (!rst && seg_if.valid && seg_if.ready) begin
      got.light_on    = seg_if.light_on;
      got.pitch       = seg_if.pitch;
      got.duration_ms = seg_if.duration_ms;
      got.last        = seg_if.last;
      sb.check_segment(got);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (char_if.valid && char_if.ready) || (seg_if.valid && seg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // offer one character, with random idle cycles ahead of it; called at a falling edge
  task automatic send_char(logic [CHAR_W-1:0] c);
    while ($urandom_range(0, 99) < src_idle) begin
      char_if.valid <= 1'b0;
      @(negedge clk);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    do @(posedge clk); while (!char_if.ready);
    sb.note_char(c);
    @(negedge clk);
  endtask

  // wait until every expected segment is out and the block has gone quiet
  task automatic settle();
    char_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(logic [DUR_W-1:0] dot, logic [DUR_W-1:0] dash,
                             logic [DUR_W-1:0] sym, logic [DUR_W-1:0] ltr);
    logic [CFG_IDX_W-1:0] regs [4];
    logic [DUR_W-1:0]     vals [4];
    regs = '{REG_DOT_TIME, REG_DASH_TIME, REG_SYMBOL_GAP, REG_LETTER_GAP};
    vals = '{dot, dash, sym, ltr};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(negedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DUR_W-1:0] rand_dur();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return DUR_W'($urandom_range(0, 1000));
      default: return DUR_W'($urandom);
    endcase
  endfunction

  // mostly letters of either case, the rest any code
  function automatic logic [CHAR_W-1:0] rand_char();
    if ($urandom_range(0, 99) < 75)
      return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) +
             CHAR_W'($urandom_range(0, 25));
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [CHAR_W-1:0] edge_chars [14];
    logic [CHAR_W-1:0] c;
    string             code_str;
    int                letters;

    edge_chars = '{"A", "Z", "a", "z", "E", "T", "Q", "Y",
                   8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B};

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    char_if.valid     = 1'b0;
    char_if.char_code = '0;
    src_idle          = 29;
    sink_idle         = 69;
    hold_req          = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset timings: range edges of letters, the letters E, T, Q and Y, and other codes
    foreach (edge_chars[i]) send_char(edge_chars[i]);
    settle();

    // all durations zero
    load_config('0, '0, '0, '0);
    send_char("B");
    send_char("m");
    settle();

    // all durations at maximum
    load_config('1, '1, '1, '1);
    send_char("H");
    send_char("j");
    settle();

    // letter gap below symbol gap: closing segment saturates
    load_config(16'd7, 16'd21, 16'd1000, 16'd10);
    send_char("O");
    send_char("x");
    settle();

    // letter gap equal to symbol gap
    load_config(16'd50, 16'd150, 16'd300, 16'd300);
    send_char("K");
    settle();

    // random phases, two per idle mode, fresh timings each time
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin src_idle = 29; sink_idle = 69; end
        1: begin src_idle = 69; sink_idle = 29; end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      load_config(rand_dur(), rand_dur(), rand_dur(), rand_dur());
      if (ph == 4) hold_req = 1'b1;
      letters = 0;
      while (letters < PHASE_LETTERS) begin
        c = rand_char();
        code_str = sb.morse_of(c);
        if (code_str.len() != 0) letters++;
        send_char(c);
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
